// File: hdl/fhp_pkg.sv
// shared types and constants for the frame header parser
`timescale 1ns / 1ps

package fhp_pkg;

    localparam int unsigned HEADER_BYTES = 13;
    localparam int unsigned COUNT_W      = 16;

    // byte offsets inside the frame header
    localparam logic [COUNT_W-1:0] OFS_MAGIC_FIRST  = 16'd0;
    localparam logic [COUNT_W-1:0] OFS_MAGIC_SECOND = 16'd1;
    localparam logic [COUNT_W-1:0] OFS_VERSION      = 16'd2;
    localparam logic [COUNT_W-1:0] OFS_TYPE         = 16'd3;
    localparam logic [COUNT_W-1:0] OFS_ROLE         = 16'd4;
    localparam logic [COUNT_W-1:0] OFS_SOURCE_LO    = 16'd5;
    localparam logic [COUNT_W-1:0] OFS_SOURCE_HI    = 16'd6;
    localparam logic [COUNT_W-1:0] OFS_DEST_LO      = 16'd7;
    localparam logic [COUNT_W-1:0] OFS_DEST_HI      = 16'd8;
    localparam logic [COUNT_W-1:0] OFS_SEQ_LO       = 16'd9;
    localparam logic [COUNT_W-1:0] OFS_SEQ_HI       = 16'd10;
    localparam logic [COUNT_W-1:0] OFS_LEN_LO       = 16'd11;
    localparam logic [COUNT_W-1:0] OFS_LEN_HI       = 16'd12;

    localparam logic [COUNT_W-1:0] HEADER_LEN  = COUNT_W'(HEADER_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // configuration register indexes
    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] REG_VERSION      = 2'd2;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TOO_SHORT   = 3'd1,
        STATUS_BAD_MAGIC   = 3'd2,
        STATUS_BAD_VERSION = 3'd3,
        STATUS_TOO_LONG    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  frame_kind;
        logic [7:0]  source_role;
        logic [15:0] source_node;
        logic [15:0] dest_node;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
    } header_t;

    // frame state as it stands once the current word is taken in
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               magic_bad;
        logic               version_bad;
        header_t            hdr;
    } frame_sum_t;

endpackage

// File: hdl/fhp_capture.sv
// per-frame byte counter, header checks and field capture
`timescale 1ns / 1ps

module fhp_capture
    import fhp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic [7:0] magic_first,
    input  logic [7:0] magic_second,
    input  logic [7:0] version_code,
    output frame_sum_t frame_next
);

    frame_sum_t frame_reg;

    always_comb begin
        frame_next = frame_reg;
        if (frame_reg.byte_count != COUNT_MAX) begin
            frame_next.byte_count = frame_reg.byte_count + 1'b1;
        end
        unique case (frame_reg.byte_count)
            OFS_MAGIC_FIRST: begin
                if (data_byte != magic_first) frame_next.magic_bad = 1'b1;
            end
            OFS_MAGIC_SECOND: begin
                if (data_byte != magic_second) frame_next.magic_bad = 1'b1;
            end
            OFS_VERSION: begin
                if (data_byte != version_code) frame_next.version_bad = 1'b1;
            end
            OFS_TYPE:      frame_next.hdr.frame_kind           = data_byte;
            OFS_ROLE:      frame_next.hdr.source_role          = data_byte;
            OFS_SOURCE_LO: frame_next.hdr.source_node[7:0]     = data_byte;
            OFS_SOURCE_HI: frame_next.hdr.source_node[15:8]    = data_byte;
            OFS_DEST_LO:   frame_next.hdr.dest_node[7:0]       = data_byte;
            OFS_DEST_HI:   frame_next.hdr.dest_node[15:8]      = data_byte;
            OFS_SEQ_LO:    frame_next.hdr.sequence_res[7:0]    = data_byte;
            OFS_SEQ_HI:    frame_next.hdr.sequence_res[15:8]   = data_byte;
            OFS_LEN_LO:    frame_next.hdr.payload_length[7:0]  = data_byte;
            OFS_LEN_HI:    frame_next.hdr.payload_length[15:8] = data_byte;
            default: ;
        endcase
    end

    // the last word of a buffer starts a fresh frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
        end else if (byte_accept) begin
            if (last_byte) begin
                frame_reg <= '0;
            end else begin
                frame_reg <= frame_next;
            end
        end
    end

endmodule

// File: hdl/fhp_result.sv
// status decision and result output register
`timescale 1ns / 1ps

module fhp_result
    import fhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        frame_done,
    input  frame_sum_t  frame_sum,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [2:0]  m_status,
    output header_t     m_hdr
);

    logic        valid_reg;
    status_t     status_reg;
    header_t     hdr_reg;
    status_t     status_next;
    header_t     hdr_next;
    logic [15:0] room;

    assign room = frame_sum.byte_count - HEADER_LEN;

    always_comb begin
        priority if (frame_sum.byte_count < HEADER_LEN) begin
            status_next = STATUS_TOO_SHORT;
        end else if (frame_sum.magic_bad) begin
            status_next = STATUS_BAD_MAGIC;
        end else if (frame_sum.version_bad) begin
            status_next = STATUS_BAD_VERSION;
        end else if (frame_sum.hdr.payload_length > room) begin
            status_next = STATUS_TOO_LONG;
        end else begin
            status_next = STATUS_OK;
        end
        if (status_next == STATUS_OK || status_next == STATUS_TOO_LONG) begin
            hdr_next = frame_sum.hdr;
        end else begin
            hdr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (frame_done) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            status_reg <= status_next;
            hdr_reg    <= hdr_next;
        end
    end

    assign m_valid  = valid_reg;
    assign m_status = status_reg;
    assign m_hdr    = hdr_reg;

endmodule

// File: hdl/frame_header_parser.sv
// top level of the frame header parser
`timescale 1ns / 1ps

// Frame header parser. A received buffer enters one byte per word on the s_
// channel, with s_last_byte set on its final byte. The block counts the bytes
// (saturating at 65535), checks bytes 0 and 1 against the magic registers and
// byte 2 against the version register, and captures the frame type, source
// role and the little-endian source node, destination node, sequence number
// and payload length from bytes 3 to 12. Each last byte yields one result word
// on the m_ channel; other bytes yield none. The status is the first that
// applies of: too short (under 13 bytes), bad magic, bad version, payload
// longer than the bytes after the header, ok. For the first three the header
// fields read zero. One word is taken per clock cycle; a result appears in the
// cycle after its last byte and sits in a single output register, and input
// stalls only while that register is full and m_ready is low. Configuration
// registers are written through cfg_we/cfg_index/cfg_wdata, index 0 first
// magic byte, 1 second magic byte, 2 version; other indexes are ignored.
// A byte is checked against the register value present when it arrives.

module frame_header_parser
    import fhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    // result out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_frame_kind,
    output logic [7:0]  m_source_role,
    output logic [15:0] m_source_node,
    output logic [15:0] m_dest_node,
    output logic [15:0] m_sequence_res,
    output logic [15:0] m_payload_length
);

    logic [7:0] magic_first_reg;
    logic [7:0] magic_second_reg;
    logic [7:0] version_code_reg;

    logic       byte_accept;
    logic       frame_done;
    frame_sum_t frame_sum;
    header_t    out_hdr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_first_reg  <= '0;
            magic_second_reg <= '0;
            version_code_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAGIC_FIRST:  magic_first_reg  <= cfg_wdata;
                REG_MAGIC_SECOND: magic_second_reg <= cfg_wdata;
                REG_VERSION:      version_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stalls only when the result register is full and not draining
    assign s_ready     = !m_valid || m_ready;
    assign byte_accept = s_valid && s_ready;
    assign frame_done  = byte_accept && s_last_byte;

    fhp_capture u_capture (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .data_byte    (s_data_byte),
        .last_byte    (s_last_byte),
        .magic_first  (magic_first_reg),
        .magic_second (magic_second_reg),
        .version_code (version_code_reg),
        .frame_next   (frame_sum)
    );

    fhp_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_done (frame_done),
        .frame_sum  (frame_sum),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_status   (m_status),
        .m_hdr      (out_hdr)
    );

    // unpack the result word onto its field ports
    assign m_frame_kind     = out_hdr.frame_kind;
    assign m_source_role    = out_hdr.source_role;
    assign m_source_node    = out_hdr.source_node;
    assign m_dest_node      = out_hdr.dest_node;
    assign m_sequence_res   = out_hdr.sequence_res;
    assign m_payload_length = out_hdr.payload_length;

endmodule
